[hw/rtl/stack_with_search_minmax_assert.svh]
// Assertion macros shared by the stack RTL.
`ifndef STACK_WITH_SEARCH_MINMAX_ASSERT_SVH
`define STACK_WITH_SEARCH_MINMAX_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define SWMS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("stack invariant violated");

// Implication checked in the cycle after the antecedent.
`define SWMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack sequence violated");

`endif

[hw/rtl/swms_pkg.sv]
package swms_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = $clog2(DEPTH);

  // request codes
  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_SEARCH  = 2'd2;
  localparam logic [1:0] REQ_INSPECT = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // one stack entry with the running max/min of itself and everything below
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] max_below;
    logic signed [DATA_W-1:0] min_below;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

[hw/rtl/swms_cell.sv]
module swms_cell (
  input  logic                          clk,
  input  swms_pkg::shift_ctrl_t         ctrl,
  input  swms_pkg::entry_t              from_above,
  input  swms_pkg::entry_t              from_below,
  input  logic                          live,
  input  logic signed [swms_pkg::DATA_W-1:0] key,
  output swms_pkg::entry_t              stored,
  output logic                          match
);

  swms_pkg::entry_t slot;

  // push moves everything one cell deeper, pop one cell toward the top
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      slot <= from_above;
    end else if (ctrl.pop) begin
      slot <= from_below;
    end
  end

  assign stored = slot;
  assign match  = live && (slot.value == key);

endmodule

[hw/rtl/stack_with_search_minmax.sv]
// LIFO stack of signed 32-bit words, built as a row of 64 shifting cells.
// Cell 0 is the top; each cell also keeps the max and min of itself and all
// entries below it, so the stack-wide max/min is always read from cell 0.
// Input channel (in_valid/in_ready): req_type selects push, pop, search or
// inspect; push_value and search_key carry the operands. Output channel
// (out_valid/out_ready): one result item per input item, in order.
// Config channel (cfg_valid/cfg_ready, capacity): always ready; write only
// while the block is idle. Capacity above 64 acts as 64, zero refuses pushes.
// Result path: accepted item -> stage register -> output register (out_valid).
// Throughput: one item per cycle unless stalled; the stack updates at accept
// and the search match vector is priority-encoded in the following stage.
// Stalls: a result waits in the output register; one more item can be taken
// and held in the stage behind it, after which in_ready drops until out_ready.
// Reset (rst, synchronous): entry count 0, capacity 64, no pending result.
module stack_with_search_minmax (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic signed [31:0]                  push_value,
  input  logic signed [31:0]                  search_key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic signed [31:0]                  popped_value,
  output logic signed [31:0]                  top_value,
  output logic [6:0]                          entry_count,
  output logic                                found,
  output logic [5:0]                          found_position,
  output logic signed [31:0]                  max_value,
  output logic signed [31:0]                  min_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [6:0]                          capacity
);

`include "stack_with_search_minmax_assert.svh"

  localparam int DEPTH = swms_pkg::DEPTH;
  localparam int CNT_W = swms_pkg::CNT_W;
  localparam int POS_W = swms_pkg::POS_W;

  // configuration
  logic [6:0]       capacity_limit;
  logic [CNT_W-1:0] limit;

  // stack control
  logic [CNT_W-1:0] count;
  logic             in_fire;
  logic             push_ok;
  logic             pop_ok;
  logic [1:0]       req_status;
  swms_pkg::shift_ctrl_t ctrl;
  swms_pkg::entry_t      new_top;
  swms_pkg::entry_t      cells [DEPTH];
  logic [DEPTH-1:0]      cell_match;

  // search / result stage
  logic                  busy;
  logic                  out_free;
  logic [1:0]            st_status;
  logic signed [31:0]    st_popped;
  logic [DEPTH-1:0]      st_match;
  logic                  hit;
  logic [POS_W-1:0]      hit_idx;
  logic [CNT_W-1:0]      hit_pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= 7'd64;
    end else if (cfg_valid) begin
      capacity_limit <= capacity;
    end
  end

  assign limit = (CNT_W'(capacity_limit) > swms_pkg::DEPTH_CNT) ?
                 swms_pkg::DEPTH_CNT : CNT_W'(capacity_limit);

  // the stage can hand its result over this cycle when the output is free
  assign out_free = !out_valid || out_ready;
  assign in_ready = !busy || out_free;
  assign in_fire  = in_valid && in_ready;

  assign push_ok = (req_type == swms_pkg::REQ_PUSH) && (count < limit);
  assign pop_ok  = (req_type == swms_pkg::REQ_POP) && (count != '0);

  always_comb begin
    req_status = swms_pkg::ST_OK;
    if ((req_type == swms_pkg::REQ_PUSH) && !push_ok) begin
      req_status = swms_pkg::ST_FULL;
    end else if ((req_type == swms_pkg::REQ_POP) && !pop_ok) begin
      req_status = swms_pkg::ST_EMPTY;
    end
  end

  assign ctrl.push = in_fire && push_ok;
  assign ctrl.pop  = in_fire && pop_ok;

  // new top entry: fold the pushed word into the running max/min
  always_comb begin
    new_top.value     = push_value;
    new_top.max_below = push_value;
    new_top.min_below = push_value;
    if (count != '0) begin
      if (cells[0].max_below > push_value) begin
        new_top.max_below = cells[0].max_below;
      end
      if (cells[0].min_below < push_value) begin
        new_top.min_below = cells[0].min_below;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + 1'b1;
    end else if (ctrl.pop) begin
      count <= count - 1'b1;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    swms_pkg::entry_t above;
    swms_pkg::entry_t below;

    if (i == 0) begin : g_top
      assign above = new_top;
    end else begin : g_mid
      assign above = cells[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = cells[i+1];
    end

    swms_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .live       (count > IDX),
      .key        (search_key),
      .stored     (cells[i]),
      .match      (cell_match[i])
    );
  end

  // stage register: per-cell match flags and the request's own outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_fire) begin
      busy <= 1'b1;
    end else if (out_free) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_status <= req_status;
      st_popped <= pop_ok ? cells[0].value : '0;
      st_match  <= (req_type == swms_pkg::REQ_SEARCH) ? cell_match : '0;
    end
  end

  // topmost match = lowest cell index
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (st_match[j]) begin
        hit     = 1'b1;
        hit_idx = POS_W'(j);
      end
    end
  end

  // cell index counts from the top; the position counts from the bottom
  assign hit_pos = count - 1'b1 - CNT_W'(hit_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (busy && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // cell state read here already reflects this stage's request
  always_ff @(posedge clk) begin
    if (busy && out_free) begin
      status         <= st_status;
      popped_value   <= st_popped;
      entry_count    <= 7'(count);
      found          <= hit;
      found_position <= hit ? 6'(hit_pos) : '0;
      top_value      <= (count != '0) ? cells[0].value     : '0;
      max_value      <= (count != '0) ? cells[0].max_below : '0;
      min_value      <= (count != '0) ? cells[0].min_below : '0;
    end
  end

  `SWMS_ASSERT_ALWAYS(a_count_bound, count <= swms_pkg::DEPTH_CNT)
  `SWMS_ASSERT_NEXT(a_push_grows, ctrl.push, count == $past(count) + 1'b1)
  `SWMS_ASSERT_NEXT(a_pop_shrinks, ctrl.pop, count == $past(count) - 1'b1)
  `SWMS_ASSERT_NEXT(a_stage_holds, busy && !out_free, busy)
  `SWMS_ASSERT_ALWAYS(a_found_nonempty, !(out_valid && found) || (entry_count != '0))

endmodule
